// ----- hw/rtl/sbda_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_pkg: shared definitions for the signed binary to decimal ASCII block
// Constants for the character codes and the control group that drives the
// BCD shift register.
// ----------------------------------------------------------------------------
package sbda_pkg;

    // Default width of the signed input value.
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // Width of one BCD digit and of one output character.
    localparam int DIGIT_WIDTH = 4;
    localparam int CHAR_WIDTH  = 6;

    // ASCII codes, truncated to the character width.
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;

    // Control for the BCD shift register.
    typedef struct packed {
        logic clear;        // zero every digit
        logic dabble;       // add-3 correction, then shift in one binary bit
        logic digit_shift;  // move every digit up one place
        logic bit_in;       // binary bit shifted in on a dabble step
    } bcd_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sbda_bcd_shift.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_bcd_shift: bit-serial double-dabble BCD register
// Accumulates a binary magnitude one bit per cycle into packed BCD digits,
// then hands the digits out most significant first, one per shift.
// ----------------------------------------------------------------------------
module sbda_bcd_shift #(
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire sbda_pkg::bcd_ctrl_t              ctrl,
    output logic [sbda_pkg::DIGIT_WIDTH-1:0]      top_digit
);

    localparam int BCD_WIDTH = NUM_DIGITS * sbda_pkg::DIGIT_WIDTH;

    logic [BCD_WIDTH-1:0] bcd_reg;
    logic [BCD_WIDTH-1:0] bcd_next;
    logic [BCD_WIDTH-1:0] bcd_adj;

    // Add-3 correction on every digit that is five or more.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*sbda_pkg::DIGIT_WIDTH +: sbda_pkg::DIGIT_WIDTH] >= 4'd5)
            begin
                bcd_adj[i*sbda_pkg::DIGIT_WIDTH +: sbda_pkg::DIGIT_WIDTH] =
                    bcd_reg[i*sbda_pkg::DIGIT_WIDTH +: sbda_pkg::DIGIT_WIDTH] + 4'd3;
            end
            else
            begin
                bcd_adj[i*sbda_pkg::DIGIT_WIDTH +: sbda_pkg::DIGIT_WIDTH] =
                    bcd_reg[i*sbda_pkg::DIGIT_WIDTH +: sbda_pkg::DIGIT_WIDTH];
            end
        end
    end

    // Select the next register contents.
    always_comb
    begin
        bcd_next = bcd_reg;
        if (ctrl.clear)
        begin
            bcd_next = '0;
        end
        else if (ctrl.dabble)
        begin
            bcd_next = {bcd_adj[BCD_WIDTH-2:0], ctrl.bit_in};
        end
        else if (ctrl.digit_shift)
        begin
            bcd_next = {bcd_reg[BCD_WIDTH-sbda_pkg::DIGIT_WIDTH-1:0],
                        {sbda_pkg::DIGIT_WIDTH{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg <= '0;
        end
        else
        begin
            bcd_reg <= bcd_next;
        end
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: sbda_pkg::DIGIT_WIDTH];

endmodule
`default_nettype wire

// ----- hw/rtl/signed_binary_to_decimal_ascii.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's-complement value per input beat into its decimal text,
// one character per output beat, most significant digit first.
// ----------------------------------------------------------------------------
// One value is converted at a time. After the input beat the magnitude is
// shifted bit by bit into a double-dabble BCD register, then the minus sign
// is handled, leading zero digits are dropped at one per cycle, and each
// remaining digit leaves at one per cycle while the output side is ready.
// A negative value is preceded by '-', zero gives a single '0', the most
// negative value is converted exactly, and last marks the final character.
// The next value is taken as soon as the final character sits in the output
// register.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0]     value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [sbda_pkg::CHAR_WIDTH-1:0]        ascii_char,
    output logic                                   last
);

    // Enough digits for the magnitude of the most negative value.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SIGN = 5'b00100,
        S_SKIP = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [VALUE_WIDTH-1:0]          mag_reg, mag_next;
    logic                            neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]            bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]            dig_cnt_reg, dig_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sbda_pkg::CHAR_WIDTH-1:0] char_reg, char_next;
    logic                            last_reg, last_next;

    sbda_pkg::bcd_ctrl_t             bcd_ctrl;
    logic [sbda_pkg::DIGIT_WIDTH-1:0] top_digit;
    logic [VALUE_WIDTH-1:0]          value_u;
    logic                            slot_free;

    sbda_bcd_shift #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (bcd_ctrl),
        .top_digit (top_digit)
    );

    assign value_u   = value;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // Sequencer: load, bit-serial conversion, sign, zero skip, digit output.
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bcd_ctrl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next     = value_u[VALUE_WIDTH-1];
                    mag_next     = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1))
                                                          : value_u;
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH - 1);
                    bcd_ctrl.clear = 1'b1;
                    state_next   = S_CONV;
                end
            end

            S_CONV:
            begin
                bcd_ctrl.dabble = 1'b1;
                bcd_ctrl.bit_in = mag_reg[VALUE_WIDTH-1];
                mag_next        = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next    = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS - 1);
                    state_next   = S_SIGN;
                end
            end

            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_SKIP;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sbda_pkg::ASCII_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_SKIP;
                end
            end

            S_SKIP:
            begin
                // Drop leading zero digits, but always keep the last one.
                if (top_digit == '0 && dig_cnt_reg != '0)
                begin
                    bcd_ctrl.digit_shift = 1'b1;
                    dig_cnt_next         = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    char_next            = sbda_pkg::ASCII_ZERO +
                                           sbda_pkg::CHAR_WIDTH'(top_digit);
                    last_next            = (dig_cnt_reg == '0);
                    bcd_ctrl.digit_shift = 1'b1;
                    dig_cnt_next         = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for signed_binary_to_decimal_ascii
// Sends signed 32-bit values through the input channel and checks every
// character beat against a decimal-text predictor. A directed table covers
// zero, the extremes and the power-of-ten boundaries, and a random part
// follows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int VALUE_W    = 32;
    localparam int MAX_DIGITS = 10;
    localparam int NUM_RANDOM = 250;
    localparam int NUM_TABLE  = 20;
    localparam int TAIL_WAIT  = 80;

    // One expected character beat.
    typedef struct packed {
        logic [sbda_pkg::CHAR_WIDTH-1:0] ascii;
        logic                            last;
    } char_beat_t;

    // One directed row; an empty text means the predictor supplies the result.
    typedef struct {
        logic [VALUE_W-1:0] value;
        string              text;
    } directed_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic signed [VALUE_W-1:0]       value = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [sbda_pkg::CHAR_WIDTH-1:0] ascii_char;
    logic                            last;

    char_beat_t expected_chars[$];
    int         error_count = 0;
    int         burst_left = 0;
    int         rx_cycle = 0;

    directed_row_t directed_rows [NUM_TABLE] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'hFFFF_FFFF,  "-1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{32'hFFFF_FFF6,  "-10"},
        '{32'd99,         "99"},
        '{32'd100,        "100"},
        '{32'd2147483647, "2147483647"},
        '{32'h8000_0000,  "-2147483648"},
        '{32'h8000_0001,  "-2147483647"},
        '{32'd999999999,  "999999999"},
        '{32'd1000000000, "1000000000"},
        '{32'hC465_3600,  "-1000000000"},
        '{32'd123456789,  ""},
        '{32'h5555_5555,  ""},
        '{32'hAAAA_AAAA,  ""},
        '{32'hF0F0_F0F0,  ""},
        '{32'h0F0F_0F0F,  ""},
        '{32'd1000000001, ""}
    };

    signed_binary_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ascii_char(ascii_char),
        .last      (last)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Appends the decimal text of one value, sign first, to the expected beats.
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits [MAX_DIGITS];
        int                 count;
        char_beat_t         beat;
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        count = 0;
        do
        begin
            digits[count] = 4'(mag % 10);
            mag = mag / 10;
            count++;
        end
        while (mag != 0);
        if (v[VALUE_W-1])
        begin
            beat.ascii = sbda_pkg::ASCII_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            beat.ascii = sbda_pkg::ASCII_ZERO + sbda_pkg::CHAR_WIDTH'(digits[i]);
            beat.last = (i == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Offers one value and returns at the edge where the beat is taken.
    // Bursts of back-to-back beats alternate with random gaps; with
    // drain_first set the sender holds off until all text has come out.
    task automatic send_value(input logic [VALUE_W-1:0] v, input string text,
                              input bit drain_first);
        int         gap;
        char_beat_t beat;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (drain_first && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            value <= $urandom();
            repeat (gap) @(posedge clk);
            while (drain_first && expected_chars.size() != 0)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        if (text.len() > 0)
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                beat.ascii = sbda_pkg::CHAR_WIDTH'(text[i]);
                beat.last = (i == text.len() - 1);
                expected_chars.push_back(beat);
            end
        end
        else
        begin
            predict_decimal_text(v);
        end
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Receiver stalls: the pattern follows bits 9:8 of the cycle counter.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Every accepted character beat is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_chars
        char_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected beat, actual char %0d last %0b",
                         $time, ascii_char, last);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (ascii_char !== want.ascii)
                begin
                    $display("%0t: ascii_char mismatch, expected %0d actual %0d",
                             $time, want.ascii, ascii_char);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.last, last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random values, then drain.
    initial
    begin : stimulus
        logic [VALUE_W-1:0] v;
        longint             lo;
        longint             hi;
        int                 num_digits;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_value(directed_rows[i].value, directed_rows[i].text, 1'b0);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    v = $urandom();
                3:
                begin
                    case ($urandom_range(0, 4))
                        0: v = 32'd0;
                        1: v = 32'hFFFF_FFFF;
                        2: v = 32'h7FFF_FFFF;
                        3: v = 32'h8000_0000;
                        default: v = 32'h8000_0001;
                    endcase
                end
                default:
                begin
                    // Spread the values evenly over digit counts.
                    num_digits = $urandom_range(1, MAX_DIGITS);
                    lo = 1;
                    repeat (num_digits - 1) lo = lo * 10;
                    hi = (num_digits == MAX_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
                    if (num_digits == 1)
                        lo = 0;
                    v = $urandom_range(32'(hi), 32'(lo));
                    if ($urandom_range(0, 1) == 1)
                        v = -v;
                end
            endcase
            send_value(v, "", (n == 0) || (n == NUM_RANDOM / 2));
        end
        in_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- signed_binary_to_decimal_ascii.f -----
hw/rtl/sbda_pkg.sv
hw/rtl/sbda_bcd_shift.sv
hw/rtl/signed_binary_to_decimal_ascii.sv
tb/sv/tb.sv
